// ===== design/binding_slot_table_round_robin_unit_assert.svh =====
// Assertion macros for the binding slot table round-robin unit.
`ifndef BINDING_SLOT_TABLE_ROUND_ROBIN_UNIT_ASSERT_SVH
`define BINDING_SLOT_TABLE_ROUND_ROBIN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BST_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BST_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bst_pkg.sv =====
// Types, widths and codes shared by the binding slot table modules.
package bst_pkg;

    localparam int MAX_UNITS  = 16;
    localparam int UNIT_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CNT_W      = $clog2(MAX_UNITS + 1);
    localparam int ID_W       = 32;
    localparam int OP_W       = 2;
    localparam int TGT_W      = 8;
    localparam int CFG_W      = 5;
    localparam int OUT_UNIT_W = 4;
    localparam int STATUS_W   = 3;
    localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_AUTO   = 2'd0,
        OP_BIND   = 2'd1,
        OP_UNBIND = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_FREE     = 3'd1,
        ST_REPLACED = 3'd2,
        ST_EXPLICIT = 3'd3,
        ST_UNBOUND  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_REJECTED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOD
    } state_t;

    typedef struct packed {
        logic              en;
        logic [UNIT_W-1:0] addr;
        logic [ID_W-1:0]   data;
    } tbl_wr_t;

endpackage

// ===== design/bst_table.sv =====
// Unit table storage with per-unit valid bits so that reset frees every unit at once.
module bst_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bst_pkg::tbl_wr_t            wr,
    input  logic [bst_pkg::UNIT_W-1:0]  rd_addr,
    output logic [bst_pkg::ID_W-1:0]    rd_data
);

    logic [bst_pkg::MAX_UNITS-1:0] valid_reg;
    logic [bst_pkg::ID_W-1:0]      entry_reg [bst_pkg::MAX_UNITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    // A unit not written since reset is free and reads as zero.
    assign rd_data = valid_reg[rd_addr] ? entry_reg[rd_addr] : '0;

endmodule

// ===== design/binding_slot_table_round_robin_unit.sv =====
// Bind-at-unit, rejections and unbind with id zero or no units answer in the next cycle.
// Auto-bind and unbind scan one unit per cycle through a single comparator, stopping at
// the first hit; a miss checks all n active units; auto-bind takes the first free one.
// Failing that, replacement reduces pointer plus one modulo n by repeated subtraction.
// Busy drops as the result appears, so the next item may start in that cycle.
// Reset frees every unit, clears the round-robin pointer and sets the active count to 16.
`include "binding_slot_table_round_robin_unit_assert.svh"

module binding_slot_table_round_robin_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bst_pkg::OP_W-1:0]          op,
    input  logic [bst_pkg::ID_W-1:0]          resource_id,
    input  logic [bst_pkg::TGT_W-1:0]         target_unit,
    input  logic                              cfg_we,
    input  logic [bst_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              done,
    output logic                              ok,
    output logic [bst_pkg::OUT_UNIT_W-1:0]    unit,
    output logic [bst_pkg::STATUS_W-1:0]      status
);

    bst_pkg::state_t                 state_reg, state_next;
    logic [bst_pkg::CFG_W-1:0]       active_reg;
    logic [bst_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [bst_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [bst_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [bst_pkg::ID_W-1:0]        id_reg, id_next;
    logic [bst_pkg::OP_W-1:0]        op_reg, op_next;
    logic                            free_found_reg, free_found_next;
    logic [bst_pkg::UNIT_W-1:0]      free_idx_reg, free_idx_next;
    logic [bst_pkg::UNIT_W-1:0]      ptr_reg, ptr_next;
    logic                            done_reg;
    logic                            ok_reg;
    logic [bst_pkg::OUT_UNIT_W-1:0]  unit_reg;
    logic [bst_pkg::STATUS_W-1:0]    status_reg;

    logic [bst_pkg::CNT_W-1:0]       n_cur;
    logic [bst_pkg::ID_W-1:0]        rd_data;
    bst_pkg::tbl_wr_t                wr;
    logic                            fin;
    logic                            fin_ok;
    logic [bst_pkg::UNIT_W-1:0]      fin_unit;
    bst_pkg::status_t                fin_status;

    bst_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (idx_reg[bst_pkg::UNIT_W-1:0]),
        .rd_data (rd_data)
    );

    // Counts above the table size saturate.
    assign n_cur = (bst_pkg::CMP_W'(active_reg) > bst_pkg::CMP_W'(bst_pkg::MAX_UNITS))
                   ? bst_pkg::CNT_W'(bst_pkg::MAX_UNITS)
                   : bst_pkg::CNT_W'(active_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bst_pkg::S_IDLE;
            active_reg <= bst_pkg::ACTIVE_RESET;
            ptr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done_reg  <= fin;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        id_reg         <= id_next;
        op_reg         <= op_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        if (fin)
        begin
            ok_reg     <= fin_ok;
            unit_reg   <= bst_pkg::OUT_UNIT_W'(fin_unit);
            status_reg <= fin_status;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        id_next         = id_reg;
        op_next         = op_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ptr_next        = ptr_reg;
        fin             = 1'b0;
        fin_ok          = 1'b0;
        fin_unit        = '0;
        fin_status      = bst_pkg::ST_REJECTED;
        wr              = '0;

        unique case (state_reg)
            bst_pkg::S_IDLE:
            begin
                if (start)
                begin
                    id_next         = resource_id;
                    op_next         = op;
                    n_next          = n_cur;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    unique case (op)
                        bst_pkg::OP_AUTO:
                        begin
                            if (resource_id == '0 || n_cur == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = bst_pkg::S_SCAN;
                            end
                        end
                        bst_pkg::OP_BIND:
                        begin
                            fin = 1'b1;
                            if ((bst_pkg::TGT_W + 1)'(target_unit) <
                                (bst_pkg::TGT_W + 1)'(n_cur))
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = target_unit[bst_pkg::UNIT_W-1:0];
                                wr.data    = resource_id;
                                fin_ok     = 1'b1;
                                fin_unit   = target_unit[bst_pkg::UNIT_W-1:0];
                                fin_status = bst_pkg::ST_EXPLICIT;
                            end
                        end
                        bst_pkg::OP_UNBIND:
                        begin
                            if (resource_id == '0 || n_cur == '0)
                            begin
                                fin        = 1'b1;
                                fin_ok     = 1'b1;
                                fin_status = bst_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = bst_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            bst_pkg::S_SCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    // Every active unit has been compared without a hit.
                    if (op_reg == bst_pkg::OP_UNBIND)
                    begin
                        fin        = 1'b1;
                        fin_ok     = 1'b1;
                        fin_status = bst_pkg::ST_NOTFOUND;
                        state_next = bst_pkg::S_IDLE;
                    end
                    else if (free_found_reg)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = free_idx_reg;
                        wr.data    = id_reg;
                        fin        = 1'b1;
                        fin_ok     = 1'b1;
                        fin_unit   = free_idx_reg;
                        fin_status = bst_pkg::ST_FREE;
                        state_next = bst_pkg::S_IDLE;
                    end
                    else
                    begin
                        rem_next   = bst_pkg::CNT_W'(ptr_reg) + bst_pkg::CNT_W'(1);
                        state_next = bst_pkg::S_MOD;
                    end
                end
                else if (rd_data == id_reg)
                begin
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    fin_unit   = idx_reg[bst_pkg::UNIT_W-1:0];
                    state_next = bst_pkg::S_IDLE;
                    if (op_reg == bst_pkg::OP_UNBIND)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = idx_reg[bst_pkg::UNIT_W-1:0];
                        wr.data    = '0;
                        fin_status = bst_pkg::ST_UNBOUND;
                    end
                    else
                    begin
                        fin_status = bst_pkg::ST_HIT;
                    end
                end
                else
                begin
                    if (rd_data == '0 && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg[bst_pkg::UNIT_W-1:0];
                    end
                    idx_next = idx_reg + bst_pkg::CNT_W'(1);
                end
            end

            bst_pkg::S_MOD:
            begin
                // The pointer may sit beyond a reduced count, so subtract until it fits.
                if (rem_reg >= n_reg)
                begin
                    rem_next = rem_reg - n_reg;
                end
                else
                begin
                    wr.en      = 1'b1;
                    wr.addr    = rem_reg[bst_pkg::UNIT_W-1:0];
                    wr.data    = id_reg;
                    ptr_next   = rem_reg[bst_pkg::UNIT_W-1:0];
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    fin_unit   = rem_reg[bst_pkg::UNIT_W-1:0];
                    fin_status = bst_pkg::ST_REPLACED;
                    state_next = bst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bst_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != bst_pkg::S_IDLE);
    assign done   = done_reg;
    assign ok     = ok_reg;
    assign unit   = unit_reg;
    assign status = status_reg;

    `BST_CHECK(a_scan_in_range, state_reg == bst_pkg::S_SCAN, idx_reg <= n_reg, "scan index passed the active count")
    `BST_CHECK(a_mod_count, state_reg == bst_pkg::S_MOD, n_reg != '0, "modulo step with no active units")
    `BST_CHECK(a_reject_form, done && !ok, status == bst_pkg::ST_REJECTED && unit == '0, "failed item not reported as rejected at unit zero")
    `BST_CHECK_NEXT(a_bind_direct, start && !busy && op == bst_pkg::OP_BIND, done && !busy, "bind at unit did not finish in one cycle")

endmodule
